@@ rtl/bif_pkg.sv @@
package bif_pkg;

  // Slots kept per vertex and the bone range accepted on add
  localparam int NSLOT     = 4;
  localparam int MAX_BONES = 256;

  localparam int FILL_W = $clog2(NSLOT + 1);
  localparam int SUM_W  = $clog2(NSLOT * 65535 + 1);

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic        op;
    logic [15:0] vertex_id;
    logic [7:0]  bone_index;
    logic [15:0] weight;
  } item_t;

  typedef struct packed {
    logic [12:0] vertex_count;
  } cfg_t;

  typedef struct packed {
    logic [11:0] vertex_echo;
    logic [2:0]  used_slots;
    logic [7:0]  bone_a;
    logic [15:0] weight_a;
    logic [7:0]  bone_b;
    logic [15:0] weight_b;
    logic [7:0]  bone_c;
    logic [15:0] weight_c;
    logic [7:0]  bone_d;
    logic [15:0] weight_d;
  } result_t;

  // One memory word: bones and weights of all slots, heaviest first
  typedef struct packed {
    logic [NSLOT-1:0][7:0]  bone;
    logic [NSLOT-1:0][15:0] wgt;
  } slot_t;

  typedef struct packed {
    logic                   start;
    logic [SUM_W-1:0]       sum;
    logic [NSLOT-1:0][15:0] wgt;
  } norm_req_t;

  typedef struct packed {
    logic                   done;
    logic [NSLOT-1:0][15:0] quot;
  } norm_rsp_t;

endpackage

@@ rtl/bif_chan_if.sv @@
interface bif_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/bif_norm.sv @@
module bif_norm
  import bif_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  norm_req_t req,
  output norm_rsp_t rsp
);

  localparam int STEPS = 16;
  localparam int CW    = $clog2(STEPS);

  logic                        busy;
  logic                        done;
  logic [CW-1:0]               cnt;
  logic [SUM_W-1:0]            divisor;
  logic [NSLOT-1:0][SUM_W-1:0] rem;
  logic [NSLOT-1:0][15:0]      low;
  logic [NSLOT-1:0][15:0]      quot;
  logic [NSLOT-1:0][31:0]      dvd;
  logic [NSLOT-1:0][SUM_W:0]   trial;
  logic [NSLOT-1:0]            qbit;

  // w * 65535 = (w << 16) - w; the upper half is always below the sum,
  // so sixteen restoring steps give the whole quotient
  always_comb begin
    for (int k = 0; k < NSLOT; k++) begin
      dvd[k]   = {req.wgt[k], 16'h0000} - {16'h0000, req.wgt[k]};
      trial[k] = {rem[k], low[k][15]};
      qbit[k]  = trial[k] >= {1'b0, divisor};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor <= req.sum;
      for (int k = 0; k < NSLOT; k++) begin
        rem[k] <= SUM_W'(dvd[k][31:16]);
        low[k] <= dvd[k][15:0];
      end
    end else if (busy) begin
      for (int k = 0; k < NSLOT; k++) begin
        if (qbit[k]) begin
          rem[k] <= SUM_W'(trial[k] - {1'b0, divisor});
        end else begin
          rem[k] <= trial[k][SUM_W-1:0];
        end
        low[k]  <= {low[k][14:0], 1'b0};
        quot[k] <= {quot[k][14:0], qbit[k]};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

@@ rtl/top4_bone_influence_select_top.sv @@
// Per-vertex top-four bone influence store with normalised read-out.
//
// items (sink): op, vertex_id, bone_index, weight. An add inserts the
//   influence into the vertex's list, heaviest first, earlier arrival first
//   on equal weights; the lightest of five falls off. A read returns the
//   vertex's slots scaled to sum to one (floor(w * 65535 / sum)) and empties
//   the vertex. Items with a vertex at or above vertex_count or MAX_VERTICES,
//   zero-weight adds and out-of-range bones are dropped with no result.
// results (source): one transaction per accepted read.
// cfg (sink): vertex_count, always ready; write it only while idle.
//
// One item at a time, through the slot memory's single read port:
//   a dropped item is only consumed, an add reads, then modifies and writes
//   back, and a read fetches, runs the 16-step restoring divider lanes and
//   then loads the result register.
// Reset: a clearing pass zeroes the fill counts, one vertex a cycle, over
//   all MAX_VERTICES vertices; items are held off until it ends.
// A stalled receiver keeps the result register; the block still accepts
//   adds, and the next read waits, holding off all items, for the register to empty.
module top4_bone_influence_select_top
  import bif_pkg::*;
#(
  parameter int MAX_VERTICES = 4096
) (
  input logic        clk,
  input logic        rst,
  bif_chan_if.sink   items,
  bif_chan_if.source results,
  bif_chan_if.sink   cfg
);

  localparam int          AW   = $clog2(MAX_VERTICES);
  localparam logic [16:0] VMAX = 17'(MAX_VERTICES);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FETCH = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_HOLD  = 3'd4;

  logic [2:0]        state;
  logic [12:0]       vertex_count;
  logic [AW-1:0]     clr_addr;
  item_t             cur;
  slot_t             slot_q;
  logic [FILL_W-1:0] fill_q;
  logic [FILL_W-1:0] used;
  slot_t             held;
  logic              out_valid;
  result_t           out_data;

  slot_t             slot_mem [MAX_VERTICES];
  logic [FILL_W-1:0] fill_mem [MAX_VERTICES];

  logic              accept;
  logic              take;
  logic [16:0]       limit;
  logic              in_range;
  logic              add_ok;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     cur_addr;
  logic [NSLOT-1:0]  ge;
  slot_t             slot_new;
  logic [FILL_W-1:0] fill_new;
  logic              slot_we;
  logic              fill_we;
  logic [AW-1:0]     fill_waddr;
  logic [FILL_W-1:0] fill_wdata;
  logic              load;
  norm_req_t         norm_req;
  norm_rsp_t         norm_rsp;
  logic [NSLOT-1:0][7:0]  bone_o;
  logic [NSLOT-1:0][15:0] wgt_o;
  result_t           res;

  // Input side
  assign items.ready = (state == ST_IDLE);
  assign accept      = items.valid && items.ready;
  assign limit       = (17'(vertex_count) < VMAX) ? 17'(vertex_count) : VMAX;
  assign in_range    = 17'(items.data.vertex_id) < limit;
  assign add_ok      = (items.data.weight != 16'h0000)
                       && (32'(items.data.bone_index) < MAX_BONES);
  assign take        = accept && in_range && ((items.data.op == OP_READ) || add_ok);
  assign rd_addr     = items.data.vertex_id[AW-1:0];
  assign cur_addr    = cur.vertex_id[AW-1:0];

  assign cfg.ready = 1'b1;

  // Sorted insert: slots that stay ahead of the new weight form a prefix
  always_comb begin
    for (int k = 0; k < NSLOT; k++) begin
      ge[k] = (FILL_W'(k) < fill_q) && (slot_q.wgt[k] >= cur.weight);
    end
    for (int k = 0; k < NSLOT; k++) begin
      if (ge[k]) begin
        slot_new.bone[k] = slot_q.bone[k];
        slot_new.wgt[k]  = slot_q.wgt[k];
      end else if (k == 0 || ge[(k == 0) ? 0 : k - 1]) begin
        slot_new.bone[k] = cur.bone_index;
        slot_new.wgt[k]  = cur.weight;
      end else begin
        slot_new.bone[k] = slot_q.bone[(k == 0) ? 0 : k - 1];
        slot_new.wgt[k]  = slot_q.wgt[(k == 0) ? 0 : k - 1];
      end
    end
    fill_new = (fill_q < FILL_W'(NSLOT)) ? fill_q + 1'b1 : fill_q;
  end

  // Too light for a full vertex: no write
  assign slot_we = (state == ST_FETCH) && (cur.op == OP_ADD) && !ge[NSLOT-1];

  always_comb begin
    fill_we    = 1'b0;
    fill_waddr = cur_addr;
    fill_wdata = '0;
    if (state == ST_CLEAR) begin
      fill_we    = 1'b1;
      fill_waddr = clr_addr;
    end else if (slot_we) begin
      fill_we    = 1'b1;
      fill_wdata = fill_new;
    end else if ((state == ST_FETCH) && (cur.op == OP_READ)) begin
      fill_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_q <= slot_mem[rd_addr];
      fill_q <= fill_mem[rd_addr];
    end
    if (slot_we) begin
      slot_mem[cur_addr] <= slot_new;
    end
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
  end

  // Normalisation request: only filled slots count towards the sum
  always_comb begin
    norm_req.start = (state == ST_FETCH) && (cur.op == OP_READ);
    norm_req.sum   = '0;
    for (int k = 0; k < NSLOT; k++) begin
      norm_req.wgt[k] = (FILL_W'(k) < fill_q) ? slot_q.wgt[k] : 16'h0000;
      norm_req.sum    = norm_req.sum + SUM_W'(norm_req.wgt[k]);
    end
  end

  bif_norm u_norm (
    .clk (clk),
    .rst (rst),
    .req (norm_req),
    .rsp (norm_rsp)
  );

  always_comb begin
    for (int k = 0; k < NSLOT; k++) begin
      bone_o[k] = (FILL_W'(k) < used) ? held.bone[k] : 8'h00;
      wgt_o[k]  = (FILL_W'(k) < used) ? norm_rsp.quot[k] : 16'h0000;
    end
    res.vertex_echo = cur.vertex_id[11:0];
    res.used_slots  = 3'(used);
    res.bone_a      = bone_o[0];
    res.weight_a    = wgt_o[0];
    res.bone_b      = bone_o[1];
    res.weight_b    = wgt_o[1];
    res.bone_c      = bone_o[2];
    res.weight_c    = wgt_o[2];
    res.bone_d      = bone_o[3];
    res.weight_d    = wgt_o[3];
  end

  assign load = (state == ST_HOLD) && (!out_valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      vertex_count <= 13'd4096;
      out_valid    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        vertex_count <= cfg.data.vertex_count;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(MAX_VERTICES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (take) begin
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          state <= (cur.op == OP_READ) ? ST_DIV : ST_IDLE;
        end
        ST_DIV: begin
          if (norm_rsp.done) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= items.data;
    end
    if (norm_req.start) begin
      used <= fill_q;
      held <= slot_q;
    end
    if (load) begin
      out_data <= res;
    end
  end

  assign results.valid = out_valid;
  assign results.data  = out_data;

`ifndef NO_ASSERTIONS
  a_rst_clears: assert property (@(posedge clk) rst |=> (state == ST_CLEAR))
    else $error("clearing pass did not restart after reset");

  a_result_from_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_HOLD))
    else $error("result raised without a finished read-out");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_we |-> (fill_wdata <= FILL_W'(NSLOT)))
    else $error("fill count beyond slot count");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    norm_rsp.done |-> (state == ST_DIV))
    else $error("divider finished outside a read-out");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!slot_we && !fill_we))
    else $error("memory written while idle");
`endif

endmodule
